FILE: rtl/core/bsss_pkg.sv
// ----------------------------------------------------------------------------
// bsss_pkg
// Shared types, codes and helpers of the bus sensor scan sequencer.
// ----------------------------------------------------------------------------
package bsss_pkg;

    localparam int MAX_SENSORS = 16;
    localparam int SIDX_W      = $clog2(MAX_SENSORS + 1);
    localparam int Q_COUNT     = 7;
    localparam int QIDX_W      = $clog2(Q_COUNT + 1);

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 128;

    // input function codes
    localparam logic [1:0] FN_START = 2'd0;
    localparam logic [1:0] FN_TICK  = 2'd1;
    localparam logic [1:0] FN_REPLY = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_QUERY  = 3'd0;
    localparam logic [2:0] KIND_BEGIN  = 3'd1;
    localparam logic [2:0] KIND_ENTRY  = 3'd2;
    localparam logic [2:0] KIND_END    = 3'd3;
    localparam logic [2:0] KIND_NOTIFY = 3'd4;

    // configuration register indexes
    localparam logic CFG_RETRY_LIMIT  = 1'b0;
    localparam logic CFG_SENSOR_COUNT = 1'b1;

    localparam logic [7:0]  RETRY_LIMIT_RST  = 8'd5;
    localparam logic [4:0]  SENSOR_COUNT_RST = 5'd16;
    localparam logic [63:0] FILL_DATA        = 64'hFFFF_FFFF_FFFF_FF00;
    localparam logic [7:0]  START_COUNT      = 8'hFF;

    // result selector from controller to datapath
    typedef enum logic [2:0] {
        SEL_QUERY      = 3'd0,
        SEL_BEGIN      = 3'd1,
        SEL_ENTRY      = 3'd2,
        SEL_FILL       = 3'd3,
        SEL_END        = 3'd4,
        SEL_NOTE_START = 3'd5,
        SEL_NOTE_DONE  = 3'd6
    } t_sel;

    typedef struct packed {
        logic start;
        logic reply;
        logic issue;
        logic clear_round;
        logic retry_dec;
        logic finish;
        logic load;
        t_sel sel;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic scanning;
        logic pending;
        logic round_done;
        logic q_match;
        logic in_room;
        logic retries_nz;
        logic round_err;
        logic fill_done;
        logic out_free;
    } t_status;

    function automatic logic [7:0] query_code(input logic [QIDX_W-1:0] idx);
        logic [7:0] code;
        case (idx)
            3'd0:    code = 8'h00;
            3'd1:    code = 8'h10;
            3'd2:    code = 8'h11;
            3'd3:    code = 8'h02;
            3'd4:    code = 8'h03;
            3'd5:    code = 8'h04;
            3'd6:    code = 8'h05;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

    // 0x08..0x58 in steps of 8 give 1..11
    function automatic logic [7:0] mode_code(input logic [7:0] v);
        logic [7:0] m;
        if (v[2:0] == 3'd0 && v >= 8'h08 && v <= 8'h58) begin
            m = {3'd0, v[7:3]};
        end else begin
            m = 8'h00;
        end
        return m;
    endfunction

endpackage

FILE: rtl/core/bsss_dp.sv
// ----------------------------------------------------------------------------
// bsss_dp
// Datapath: configuration, scan state, answer store and result register.
// ----------------------------------------------------------------------------
module bsss_dp
    import bsss_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [7:0]             i_cfg_data,
    input  logic [7:0]             i_reply_code,
    input  logic                   i_reply_valid,
    input  logic [7:0]             i_reply_value,
    input  logic [31:0]            i_client_addr,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic                   o_out_last,
    output logic [2:0]             o_out_kind,
    output logic [OUT_TDATA_W-1:0] o_out_data
);

    logic [7:0]        r_retry_limit;
    logic [4:0]        r_sensor_count;
    logic              r_scanning;
    logic [QIDX_W-1:0] r_q_idx;
    logic              r_pending;
    logic [7:0]        r_answers [Q_COUNT];
    logic              r_round_err;
    logic [SIDX_W-1:0] r_sensor_idx;
    logic [7:0]        r_retries;
    logic [31:0]       r_stored_addr;
    logic [SIDX_W-1:0] r_fill_idx;

    logic              r_out_valid;
    logic              r_out_last;
    logic [2:0]        r_out_kind;
    logic [7:0]        r_dest;
    logic [7:0]        r_qcode;
    logic [3:0]        r_eidx;
    logic [63:0]       r_edata;
    logic              r_nphase;
    logic [7:0]        r_ncount;
    logic [31:0]       r_naddr;

    logic [2:0]        n_kind;
    logic [7:0]        n_dest;
    logic [7:0]        n_qcode;
    logic [3:0]        n_eidx;
    logic [63:0]       n_edata;
    logic              n_nphase;
    logic [7:0]        n_ncount;
    logic [31:0]       n_naddr;

    logic [SIDX_W-1:0] limit;
    logic              out_free;

    assign limit    = (r_sensor_count > SIDX_W'(MAX_SENSORS)) ? SIDX_W'(MAX_SENSORS)
                                                              : SIDX_W'(r_sensor_count);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_status.scanning   = r_scanning;
        o_status.pending    = r_pending;
        o_status.round_done = (r_q_idx == QIDX_W'(Q_COUNT));
        o_status.q_match    = r_pending && (query_code(r_q_idx) == i_reply_code);
        o_status.in_room    = (r_sensor_idx < limit);
        o_status.retries_nz = (r_retries != 8'd0);
        o_status.round_err  = r_round_err;
        o_status.fill_done  = (r_fill_idx == SIDX_W'(MAX_SENSORS));
        o_status.out_free   = out_free;
    end

    // result fields, unused ones zero
    always_comb begin
        n_kind   = KIND_QUERY;
        n_dest   = 8'd0;
        n_qcode  = 8'd0;
        n_eidx   = 4'd0;
        n_edata  = 64'd0;
        n_nphase = 1'b0;
        n_ncount = 8'd0;
        n_naddr  = 32'd0;
        case (i_cmd.sel)
            SEL_QUERY: begin
                n_kind  = KIND_QUERY;
                n_dest  = 8'({r_sensor_idx, 1'b1});
                n_qcode = query_code(r_q_idx);
            end
            SEL_BEGIN: begin
                n_kind = KIND_BEGIN;
            end
            SEL_ENTRY: begin
                n_kind  = KIND_ENTRY;
                n_eidx  = r_sensor_idx[3:0];
                n_edata = {r_answers[6], r_answers[5], r_answers[4], r_answers[3],
                           mode_code(r_answers[2]), r_answers[0], r_answers[1], 8'h01};
            end
            SEL_FILL: begin
                n_kind  = KIND_ENTRY;
                n_eidx  = r_fill_idx[3:0];
                n_edata = FILL_DATA;
            end
            SEL_END: begin
                n_kind = KIND_END;
            end
            SEL_NOTE_START: begin
                n_kind   = KIND_NOTIFY;
                n_ncount = START_COUNT;
                n_naddr  = r_stored_addr;
            end
            SEL_NOTE_DONE: begin
                n_kind   = KIND_NOTIFY;
                n_nphase = 1'b1;
                n_ncount = 8'(r_sensor_idx);
                n_naddr  = r_stored_addr;
            end
            default: begin
                n_kind = KIND_QUERY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit  <= RETRY_LIMIT_RST;
            r_sensor_count <= SENSOR_COUNT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_RETRY_LIMIT) begin
                r_retry_limit <= i_cfg_data;
            end else begin
                r_sensor_count <= i_cfg_data[4:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scanning    <= 1'b0;
            r_q_idx       <= '0;
            r_pending     <= 1'b0;
            r_round_err   <= 1'b0;
            r_sensor_idx  <= '0;
            r_retries     <= 8'd0;
            r_stored_addr <= 32'd0;
            r_fill_idx    <= '0;
        end else begin
            if (i_cmd.start) begin
                r_stored_addr <= i_client_addr;
                r_scanning    <= 1'b1;
                r_q_idx       <= '0;
                r_pending     <= 1'b0;
                r_round_err   <= 1'b0;
                r_sensor_idx  <= '0;
                r_retries     <= r_retry_limit;
            end
            if (i_cmd.reply) begin
                if (!i_reply_valid) begin
                    r_round_err <= 1'b1;
                end
                r_q_idx   <= r_q_idx + QIDX_W'(1);
                r_pending <= 1'b0;
            end
            if (i_cmd.issue) begin
                r_pending <= 1'b1;
            end
            if (i_cmd.clear_round) begin
                r_q_idx     <= '0;
                r_pending   <= 1'b0;
                r_round_err <= 1'b0;
            end
            if (i_cmd.retry_dec) begin
                r_retries <= r_retries - 8'd1;
            end
            if (i_cmd.finish) begin
                r_scanning <= 1'b0;
                r_fill_idx <= r_sensor_idx;
            end
            // a clean entry moves on to the next sensor once it is issued
            if (i_cmd.load && i_cmd.sel == SEL_ENTRY) begin
                r_sensor_idx <= r_sensor_idx + SIDX_W'(1);
                r_retries    <= r_retry_limit;
            end
            if (i_cmd.load && i_cmd.sel == SEL_FILL) begin
                r_fill_idx <= r_fill_idx + SIDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.reply && i_reply_valid) begin
            r_answers[r_q_idx[2:0]] <= i_reply_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_last <= i_cmd.last;
            r_out_kind <= n_kind;
            r_dest     <= n_dest;
            r_qcode    <= n_qcode;
            r_eidx     <= n_eidx;
            r_edata    <= n_edata;
            r_nphase   <= n_nphase;
            r_ncount   <= n_ncount;
            r_naddr    <= n_naddr;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_last  = r_out_last;
    assign o_out_kind  = r_out_kind;
    assign o_out_data  = {3'd0, r_naddr, r_ncount, r_nphase, r_edata, r_eidx,
                          r_qcode, r_dest};

    a_pending_in_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> (r_q_idx != QIDX_W'(Q_COUNT)))
        else $error("query pending after the round completed");

    a_sensor_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sensor_idx <= SIDX_W'(MAX_SENSORS))
        else $error("sensor index beyond table");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> out_free)
        else $error("result loaded over a waiting result");

    a_reply_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.reply |=> !r_pending)
        else $error("query still pending after its reply");

endmodule

FILE: rtl/core/bsss_ctrl.sv
// ----------------------------------------------------------------------------
// bsss_ctrl
// Controller: decodes input transactions and sequences the results.
// ----------------------------------------------------------------------------
module bsss_ctrl
    import bsss_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic [1:0] i_func,
    input  logic    i_grant,
    input  logic    i_bus_accepts,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_NOTE0 = 8'b0000_0010,
        S_BEGIN = 8'b0000_0100,
        S_QUERY = 8'b0000_1000,
        S_ENTRY = 8'b0001_0000,
        S_FILL  = 8'b0010_0000,
        S_END   = 8'b0100_0000,
        S_NOTE1 = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '{default: '0, sel: SEL_QUERY};
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_func)
                        FN_START: begin
                            if (i_grant) begin
                                o_cmd.start = 1'b1;
                                n_state     = S_NOTE0;
                            end
                        end
                        FN_TICK: begin
                            if (i_status.scanning && !i_status.pending) begin
                                if (!i_status.round_done) begin
                                    if (i_bus_accepts) begin
                                        o_cmd.issue = 1'b1;
                                        n_state     = S_QUERY;
                                    end
                                end else if (i_status.in_room && i_status.retries_nz) begin
                                    o_cmd.clear_round = 1'b1;
                                    if (i_status.round_err) begin
                                        o_cmd.retry_dec = 1'b1;
                                    end else begin
                                        n_state = S_ENTRY;
                                    end
                                end else begin
                                    o_cmd.clear_round = 1'b1;
                                    o_cmd.finish      = 1'b1;
                                    n_state           = S_FILL;
                                end
                            end
                        end
                        FN_REPLY: begin
                            o_cmd.reply = i_status.q_match;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_NOTE0: begin
                o_cmd.sel = SEL_NOTE_START;
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_BEGIN;
                end
            end
            S_BEGIN: begin
                o_cmd.sel  = SEL_BEGIN;
                o_cmd.last = 1'b1;
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_QUERY: begin
                o_cmd.sel  = SEL_QUERY;
                o_cmd.last = 1'b1;
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_ENTRY: begin
                o_cmd.sel  = SEL_ENTRY;
                o_cmd.last = 1'b1;
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_FILL: begin
                o_cmd.sel = SEL_FILL;
                // pad the remaining table slots up to the last one
                if (i_status.fill_done) begin
                    n_state = S_END;
                end else if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                end
            end
            S_END: begin
                o_cmd.sel = SEL_END;
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_NOTE1;
                end
            end
            S_NOTE1: begin
                o_cmd.sel  = SEL_NOTE_DONE;
                o_cmd.last = 1'b1;
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_cmd_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.start || o_cmd.reply || o_cmd.issue || o_cmd.finish) |-> accept)
        else $error("scan state changed without an input transaction");

    a_finish_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> (r_state == S_FILL && !i_status.scanning))
        else $error("finish did not enter the fill sequence");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_cmd.start && !o_cmd.reply)
        else $error("input decoded while results are pending");

endmodule

FILE: rtl/core/bus_sensor_scan_sequencer.sv
// ----------------------------------------------------------------------------
// bus_sensor_scan_sequencer
// Scans lighting-bus sensors and builds their configuration table.
// ----------------------------------------------------------------------------
// An input transaction that causes no result (reply, refused tick, start
// without grant) is taken while the controller stays idle. One that causes
// results holds the input side until they are all issued: two for a start,
// one for a query or table entry, and up to eighteen for the finishing fill,
// end-table and notice, where the fill state moves on only once the fill has
// passed the last table slot. The controller issues one result per cycle
// into a single output register while the output side keeps taking them; a
// stalled output holds it back. No result is dropped while a result waits.
// ----------------------------------------------------------------------------
module bus_sensor_scan_sequencer
    import bsss_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_cfg_index,
    input  logic [7:0]             i_cfg_data,
    // input items
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // grant[0], bus_accepts[1], reply_code[9:2], reply_valid[10],
    // reply_value[18:11], client_addr[50:19], zero above
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // func[1:0]
    input  logic [1:0]             s_axis_tuser,
    // results
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // dest_address[7:0], query_code[15:8], entry_index[19:16],
    // entry_data[83:20], notify_phase[84], notify_count[92:85],
    // notify_addr[124:93], zero above
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // kind[2:0]
    output logic [2:0]             m_axis_tuser,
    output logic                   m_axis_tlast
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    bsss_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_func        (s_axis_tuser),
        .i_grant       (s_axis_tdata[0]),
        .i_bus_accepts (s_axis_tdata[1]),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    bsss_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_reply_code  (s_axis_tdata[9:2]),
        .i_reply_valid (s_axis_tdata[10]),
        .i_reply_value (s_axis_tdata[18:11]),
        .i_client_addr (s_axis_tdata[50:19]),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_last    (m_axis_tlast),
        .o_out_kind    (m_axis_tuser),
        .o_out_data    (m_axis_tdata)
    );

endmodule
